### rtl/core/kvlt_pkg.sv
// Shared types and constants for the key/value line tokenizer.
// Depends on nothing; every other file of the block imports it.
package kvlt_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned CODE_W          = 3;
  localparam int unsigned LINE_W          = 16;
  localparam int unsigned VLEN_W          = 16;
  localparam int unsigned LINE_COUNT_BITS_DEF   = 16;
  localparam int unsigned VALUE_LENGTH_BITS_DEF = 16;

  localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CHAR_UNDER = 8'h5F;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_KEY     = 3'd0,
    ST_IN_KEY  = 3'd1,
    ST_COMMENT = 3'd2,
    ST_EQ      = 3'd3,
    ST_VAL     = 3'd4,
    ST_IN_VAL  = 3'd5,
    ST_ERROR   = 3'd6
  } kvlt_state_e;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE      = 3'd0,
    EV_KEY_BYTE  = 3'd1,
    EV_KEY_END   = 3'd2,
    EV_VAL_FIRST = 3'd3,
    EV_VAL_BYTE  = 3'd4,
    EV_VAL_END   = 3'd5,
    EV_ERROR     = 3'd6,
    EV_DONE      = 3'd7
  } kvlt_event_e;

  typedef enum logic [CODE_W-1:0] {
    ERR_NONE        = 3'd0,
    ERR_KEY_DIGIT   = 3'd1,
    ERR_KEY_EQ      = 3'd2,
    ERR_BAD_KEY     = 3'd3,
    ERR_NO_EQ       = 3'd4,
    ERR_BAD_VALUE   = 3'd5
  } kvlt_err_e;

  typedef struct packed {
    logic key_char;
    logic digit;
    logic blank;
    logic hash;
    logic equal;
    logic cr_lf;
    logic lf;
    logic nul;
  } kvlt_class_t;

  typedef struct packed {
    kvlt_event_e        kind;
    logic [BYTE_W-1:0]  echo;
    logic [VLEN_W-1:0]  vlen;
    logic [LINE_W-1:0]  line;
    kvlt_err_e          code;
    logic               ok;
  } kvlt_result_t;

endpackage

### rtl/core/kvlt_if.sv
// Valid/ready channel interfaces for the tokenizer's byte input and event output.
// Depends on kvlt_pkg for the field widths.
interface kvlt_in_if;
  import kvlt_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface kvlt_out_if;
  import kvlt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [BYTE_W-1:0] echo_byte;
  logic [VLEN_W-1:0] value_length;
  logic [LINE_W-1:0] line_number;
  logic [CODE_W-1:0] error_code;
  logic              parse_ok;

  modport source (output valid, output event_kind, output echo_byte, output value_length,
                  output line_number, output error_code, output parse_ok, input ready);
  modport sink   (input valid, input event_kind, input echo_byte, input value_length,
                  input line_number, input error_code, input parse_ok, output ready);
endinterface

### rtl/core/kvlt_class.sv
// ASCII character classifier for one text byte.
// Depends on kvlt_pkg for the class struct and character constants.
module kvlt_class (
  input  logic [kvlt_pkg::BYTE_W-1:0] text_byte_i,
  output kvlt_pkg::kvlt_class_t       cls_o
);
  import kvlt_pkg::*;

  logic letter;

  assign letter = ((text_byte_i >= 8'h41) && (text_byte_i <= 8'h5A)) ||
                  ((text_byte_i >= 8'h61) && (text_byte_i <= 8'h7A));

  always_comb begin
    cls_o.key_char = letter || (text_byte_i == CHAR_UNDER);
    cls_o.digit    = (text_byte_i >= 8'h30) && (text_byte_i <= 8'h39);
    cls_o.blank    = (text_byte_i == 8'h20) ||
                     ((text_byte_i >= 8'h09) && (text_byte_i <= 8'h0D));
    cls_o.hash     = (text_byte_i == CHAR_HASH);
    cls_o.equal    = (text_byte_i == CHAR_EQ);
    cls_o.cr_lf    = (text_byte_i == CHAR_CR) || (text_byte_i == CHAR_LF);
    cls_o.lf       = (text_byte_i == CHAR_LF);
    cls_o.nul      = (text_byte_i == CHAR_NUL);
  end

endmodule

### rtl/core/kvlt_step.sv
// Parser state, line and value counters, and the event for one text byte.
// Depends on kvlt_pkg; fed by kvlt_class.
module kvlt_step #(
  parameter int unsigned LINE_COUNT_BITS   = kvlt_pkg::LINE_COUNT_BITS_DEF,
  parameter int unsigned VALUE_LENGTH_BITS = kvlt_pkg::VALUE_LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  logic [kvlt_pkg::BYTE_W-1:0] text_byte_i,
  input  logic                        end_of_text_i,
  input  kvlt_pkg::kvlt_class_t       cls_i,
  output kvlt_pkg::kvlt_result_t      result_o
);
  import kvlt_pkg::*;

  localparam logic [LINE_COUNT_BITS-1:0]   LineOne = LINE_COUNT_BITS'(1);
  localparam logic [VALUE_LENGTH_BITS-1:0] VlenOne = VALUE_LENGTH_BITS'(1);

  kvlt_state_e                  state_q, state_d;
  logic [LINE_COUNT_BITS-1:0]   line_q, line_d;
  logic [VALUE_LENGTH_BITS-1:0] vbytes_q, vbytes_d;
  logic [VALUE_LENGTH_BITS-1:0] vtrim_q, vtrim_d;
  kvlt_err_e                    err_q, err_d;
  logic [LINE_COUNT_BITS-1:0]   err_line_q, err_line_d;
  logic                         eot;

  assign eot = end_of_text_i || cls_i.nul;

  always_comb begin
    kvlt_err_e                  new_err;
    logic [LINE_COUNT_BITS-1:0] line_n;
    new_err    = ERR_NONE;
    line_n     = (cls_i.lf && (line_q != '1)) ? line_q + LineOne : line_q;
    state_d    = state_q;
    line_d     = line_n;
    vbytes_d   = vbytes_q;
    vtrim_d    = vtrim_q;
    err_d      = err_q;
    err_line_d = err_line_q;
    if (eot) begin
      state_d    = ST_KEY;
      line_d     = LineOne;
      vbytes_d   = '0;
      vtrim_d    = '0;
      err_d      = ERR_NONE;
      err_line_d = '0;
    end else begin
      unique case (state_q)
        ST_KEY: begin
          priority if (cls_i.key_char) state_d = ST_IN_KEY;
          else if (cls_i.hash)         state_d = ST_COMMENT;
          else if (cls_i.blank)        state_d = ST_KEY;
          else if (cls_i.digit)        new_err = ERR_KEY_DIGIT;
          else if (cls_i.equal)        new_err = ERR_KEY_EQ;
          else                         new_err = ERR_BAD_KEY;
        end
        ST_IN_KEY: begin
          priority if (cls_i.blank) state_d = ST_EQ;
          else if (cls_i.equal)     state_d = ST_VAL;
          else if (cls_i.key_char)  state_d = ST_IN_KEY;
          else                      new_err = ERR_BAD_KEY;
        end
        ST_COMMENT: begin
          if (cls_i.cr_lf) state_d = ST_KEY;
        end
        ST_EQ: begin
          priority if (cls_i.equal) state_d = ST_VAL;
          else if (!cls_i.blank)    new_err = ERR_NO_EQ;
          else                      state_d = ST_EQ;
        end
        ST_VAL: begin
          priority if (cls_i.blank)           state_d = ST_VAL;
          else if (cls_i.hash || cls_i.equal) new_err = ERR_BAD_VALUE;
          else begin
            state_d  = ST_IN_VAL;
            vbytes_d = VlenOne;
            vtrim_d  = VlenOne;
          end
        end
        ST_IN_VAL: begin
          if (cls_i.cr_lf) begin
            state_d  = ST_KEY;
            vbytes_d = '0;
            vtrim_d  = '0;
          end else begin
            vbytes_d = (vbytes_q != '1) ? vbytes_q + VlenOne : vbytes_q;
            if (!cls_i.blank) vtrim_d = vbytes_d;
          end
        end
        default: state_d = state_q;
      endcase
      if (new_err != ERR_NONE) begin
        err_d      = new_err;
        err_line_d = line_n;
        state_d    = ST_ERROR;
      end
    end
  end

  always_comb begin
    result_o.kind = EV_NONE;
    result_o.echo = '0;
    result_o.vlen = '0;
    result_o.ok   = 1'b0;
    if (eot) begin
      result_o.kind = EV_DONE;
      if (state_q == ST_IN_VAL) result_o.vlen = VLEN_W'(vbytes_q);
      result_o.ok   = (err_q == ERR_NONE);
      result_o.line = (err_q != ERR_NONE) ? LINE_W'(err_line_q) : LINE_W'(line_q);
      result_o.code = err_q;
    end else begin
      if (err_d != err_q) begin
        result_o.kind = EV_ERROR;
      end else begin
        unique case (state_q)
          ST_KEY, ST_IN_KEY: begin
            if (cls_i.key_char) begin
              result_o.kind = EV_KEY_BYTE;
              result_o.echo = text_byte_i;
            end else if ((state_q == ST_IN_KEY) && (cls_i.blank || cls_i.equal)) begin
              result_o.kind = EV_KEY_END;
            end
          end
          ST_VAL: begin
            if (state_d == ST_IN_VAL) begin
              result_o.kind = EV_VAL_FIRST;
              result_o.echo = text_byte_i;
            end
          end
          ST_IN_VAL: begin
            if (cls_i.cr_lf) begin
              result_o.kind = EV_VAL_END;
              result_o.vlen = VLEN_W'(vtrim_q);
            end else begin
              result_o.kind = EV_VAL_BYTE;
              result_o.echo = text_byte_i;
            end
          end
          default: result_o.kind = EV_NONE;
        endcase
      end
      result_o.line = (err_d != ERR_NONE) ? LINE_W'(err_line_d) : LINE_W'(line_d);
      result_o.code = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_KEY;
      line_q     <= LineOne;
      vbytes_q   <= '0;
      vtrim_q    <= '0;
      err_q      <= ERR_NONE;
      err_line_q <= '0;
    end else if (step_en_i) begin
      state_q    <= state_d;
      line_q     <= line_d;
      vbytes_q   <= vbytes_d;
      vtrim_q    <= vtrim_d;
      err_q      <= err_d;
      err_line_q <= err_line_d;
    end
  end

endmodule

### rtl/core/key_value_line_tokenizer.sv
// Key/value line tokenizer: turns "key = value" text, one byte per item, into events.
// Depends on kvlt_pkg, kvlt_if, kvlt_class and kvlt_step.
//
// byte_i takes one text byte (or an end-of-text mark; a NUL byte counts as one)
// per item. event_o gives exactly one event per input item: none, key byte, key
// end, value first, value byte, value end with trimmed length, error, or done
// with the final status. Both channels are valid/ready.
// An item is held in an input register, parsed by the state machine and counters
// in kvlt_step, and its event lands in the output register; a stall on event_o
// can hold the item between the two. One item per cycle is sustained while
// event_o does not stall; parser state and counters update once for each item.
// When event_o stalls, the output register holds its event and the input
// register holds the next byte; byte_i.ready drops once both are full.
// The first error sticks with its line until end of text; the done event
// returns the parser to its reset state. Reset puts the parser at "looking for
// key" with line count one, and empties both registers.
module key_value_line_tokenizer #(
  parameter int unsigned LINE_COUNT_BITS   = kvlt_pkg::LINE_COUNT_BITS_DEF,
  parameter int unsigned VALUE_LENGTH_BITS = kvlt_pkg::VALUE_LENGTH_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  kvlt_in_if.sink        byte_i,
  kvlt_out_if.source     event_o
);
  import kvlt_pkg::*;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_eot_q;
  logic              out_valid_q;
  kvlt_result_t      out_q;
  kvlt_result_t      result;
  kvlt_class_t       cls;
  logic              advance;
  logic              step_en;

  assign advance      = !out_valid_q || event_o.ready;
  assign byte_i.ready = !in_valid_q || advance;
  assign step_en      = in_valid_q && advance;

  kvlt_class u_class (
    .text_byte_i (in_byte_q),
    .cls_o       (cls)
  );

  kvlt_step #(
    .LINE_COUNT_BITS   (LINE_COUNT_BITS),
    .VALUE_LENGTH_BITS (VALUE_LENGTH_BITS)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .text_byte_i   (in_byte_q),
    .end_of_text_i (in_eot_q),
    .cls_i         (cls),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (byte_i.ready) in_valid_q <= byte_i.valid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.text_byte;
      in_eot_q  <= byte_i.end_of_text;
    end
    if (step_en) out_q <= result;
  end

  assign event_o.valid        = out_valid_q;
  assign event_o.event_kind   = out_q.kind;
  assign event_o.echo_byte    = out_q.echo;
  assign event_o.value_length = out_q.vlen;
  assign event_o.line_number  = out_q.line;
  assign event_o.error_code   = out_q.code;
  assign event_o.parse_ok     = out_q.ok;

endmodule
